/* hdl/assert_macros.svh */
// Assertion macros shared by the executor modules; they use clk_i and rst_ni of the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCE_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCE_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) else $error(msg);

`endif

/* hdl/tce_pkg.sv */
// Shared types and constants of the tiny CPU instruction executor.
`timescale 1ns / 1ps
package tce_pkg;

  // Default data memory depth in words.
  localparam int unsigned TCE_MEM_WORDS = 256;
  // Entries in the queue between decode and execute.
  localparam int unsigned TCE_QUEUE_DEPTH = 2;

  // Instruction format codes in bits 1:0.
  localparam logic [1:0] FMT_BRANCH = 2'b10;
  localparam logic [1:0] FMT_MEMORY = 2'b11;

  // Compare flag codes.
  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_GT = 2'd1;
  localparam logic [1:0] CMP_LT = 2'd2;

  typedef enum logic [1:0] {
    K_ALU,
    K_BRANCH,
    K_LOAD,
    K_STORE
  } kind_e;

  typedef enum logic [1:0] {
    OP_INC,
    OP_DEC,
    OP_SHL,
    OP_SHR
  } alu_op_e;

  // Execute sequencer states.
  typedef enum logic [2:0] {
    ST_RUN,
    ST_DIV1,
    ST_DIV2,
    ST_MEM,
    ST_LOAD
  } exec_state_e;

  // One classified instruction.
  typedef struct packed {
    kind_e       kind;
    alu_op_e     op;
    logic [2:0]  rx;
    logic [2:0]  ry;
    logic [1:0]  cond;
    logic [11:0] target;
  } dec_t;

endpackage

/* hdl/tce_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module tce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/tce_front.sv */
// Front end: accepts instruction requests and classifies them for the queue.
`timescale 1ns / 1ps
module tce_front (
  input  logic          enable_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [15:0]   instr_word_i,
  input  logic          full_i,
  output logic          push_o,
  output tce_pkg::dec_t push_data_o
);
  import tce_pkg::*;

  logic [1:0] fmt;

  // Accept while the queue has room and the memory clear has finished.
  assign in_ready_o = enable_i && !full_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign fmt        = instr_word_i[1:0];

  // Classify the instruction word.
  always_comb begin
    push_data_o.rx     = instr_word_i[15:13];
    push_data_o.ry     = instr_word_i[12:10];
    push_data_o.cond   = instr_word_i[3:2];
    push_data_o.target = instr_word_i[15:4];
    unique case ({instr_word_i[2], instr_word_i[0]})
      2'b00:   push_data_o.op = OP_INC;
      2'b01:   push_data_o.op = OP_DEC;
      2'b10:   push_data_o.op = OP_SHL;
      default: push_data_o.op = OP_SHR;
    endcase
    unique case (fmt)
      FMT_BRANCH: push_data_o.kind = K_BRANCH;
      FMT_MEMORY: push_data_o.kind = instr_word_i[2] ? K_STORE : K_LOAD;
      default:    push_data_o.kind = K_ALU;
    endcase
  end

endmodule

/* hdl/tce_queue.sv */
// Short queue of classified instructions between front and back ends.
`timescale 1ns / 1ps
module tce_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tce_pkg::dec_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tce_pkg::dec_t head_o
);
  import tce_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned PW = $clog2(TCE_QUEUE_DEPTH);

  dec_t          entries_q [TCE_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(TCE_QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entries_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TCE_ASSERT_SAME(a_pop_needs_entry, pop_i, valid_o, "queue popped while empty")

endmodule

/* hdl/tce_back.sv */
// Back end: register file, ALU, branch logic, data memory access and result register.
`timescale 1ns / 1ps
module tce_back #(
  parameter int unsigned MEM_WORDS = tce_pkg::TCE_MEM_WORDS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  tce_pkg::dec_t q_head_i,
  output logic          pop_o,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [15:0]   result_value_o,
  output logic [15:0]   reg0_value_o,
  output logic [15:0]   next_pc_o,
  output logic [1:0]    compare_out_o,
  output logic          was_branch_o
);
  import tce_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW      = $clog2(MEM_WORDS);
  localparam bit          IS_POW2 = ((1 << AW) == MEM_WORDS);
  localparam int unsigned SH      = 16 + AW;
  // Rounded-up reciprocal: floor(v / MEM_WORDS) == (v * RECIP) >> SH for 16-bit v.
  localparam logic [63:0] RECIP   = ((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);

  exec_state_e state_q, state_d;

  logic [15:0]   rf_q [8];
  logic [1:0]    flag_q, flag_d;
  logic [15:0]   pc_q, pc_d;
  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;

  logic [2:0]    mrx_q;
  logic          is_ld_q;
  logic [15:0]   ryv_q;
  logic [15:0]   quot_q;
  logic [AW-1:0] addr_q;

  logic          out_valid_q;
  logic [15:0]   res_q, r0_q, pc_out_q;
  logic [1:0]    cmp_q;
  logic          br_q;

  logic        can_emit, emit, mem_start;
  logic        rf_we;
  logic [2:0]  rf_wa;
  logic [15:0] rf_wd;
  logic [15:0] rxv, ryv, alu_new, ry_new;
  logic [15:0] res_d, r0_d;
  logic        br_d;
  logic        ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [15:0] ram_wdata, ram_rdata;
  logic [32:0] prod, quot_full;
  logic [15:0] quot_d;
  logic [31:0] qn;
  logic [15:0] rem;

  assign can_emit = !out_valid_q || out_ready_i;
  assign ready_o  = !clr_busy_q;
  assign rxv      = rf_q[q_head_i.rx];
  assign ryv      = rf_q[q_head_i.ry];

  // ALU operation on register rx; ry sees the new value when it names the same register.
  always_comb begin
    case (q_head_i.op)
      OP_INC:  alu_new = rxv + 16'd1;
      OP_DEC:  alu_new = rxv - 16'd1;
      OP_SHL:  alu_new = {rxv[14:0], 1'b0};
      default: alu_new = {1'b0, rxv[15:1]};
    endcase
    ry_new = (q_head_i.ry == q_head_i.rx) ? alu_new : ryv;
  end

  // Address reduction modulo the memory depth, one multiply per cycle.
  assign prod      = {17'd0, ryv_q} * {16'd0, RECIP[16:0]};
  assign quot_full = prod >> SH;
  assign quot_d    = quot_full[15:0];
  assign qn        = {16'd0, quot_q} * 32'(MEM_WORDS);
  assign rem       = ryv_q - qn[15:0];

  // Execute control and datapath selection.
  always_comb begin
    pop_o     = 1'b0;
    emit      = 1'b0;
    mem_start = 1'b0;
    rf_we     = 1'b0;
    rf_wa     = q_head_i.rx;
    rf_wd     = alu_new;
    flag_d    = flag_q;
    pc_d      = pc_q;
    res_d     = rf_q[0];
    r0_d      = rf_q[0];
    br_d      = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (!clr_busy_q && q_valid_i) begin
          unique case (q_head_i.kind)
            K_ALU: begin
              if (can_emit) begin
                pop_o = 1'b1;
                emit  = 1'b1;
                rf_we = 1'b1;
                pc_d  = pc_q + 16'd1;
                res_d = alu_new;
                r0_d  = (q_head_i.rx == 3'd0) ? alu_new : rf_q[0];
                if (alu_new == ry_new) begin
                  flag_d = CMP_EQ;
                end else if (alu_new > ry_new) begin
                  flag_d = CMP_GT;
                end else begin
                  flag_d = CMP_LT;
                end
              end
            end
            K_BRANCH: begin
              if (can_emit) begin
                pop_o = 1'b1;
                emit  = 1'b1;
                br_d  = 1'b1;
                pc_d  = (flag_q == q_head_i.cond) ? {4'd0, q_head_i.target} : pc_q + 16'd1;
              end
            end
            default: begin
              pop_o     = 1'b1;
              mem_start = 1'b1;
            end
          endcase
        end
      end
      ST_DIV1, ST_DIV2: begin
      end
      ST_MEM: begin
        if (is_ld_q) begin
          ram_re = 1'b1;
        end else if (can_emit) begin
          ram_we = 1'b1;
          emit   = 1'b1;
          pc_d   = pc_q + 16'd1;
          res_d  = rf_q[mrx_q];
        end
      end
      ST_LOAD: begin
        if (can_emit) begin
          emit  = 1'b1;
          rf_we = 1'b1;
          rf_wa = mrx_q;
          rf_wd = ram_rdata;
          pc_d  = pc_q + 16'd1;
          res_d = ram_rdata;
          r0_d  = (mrx_q == 3'd0) ? ram_rdata : rf_q[0];
        end
      end
      default: begin
      end
    endcase
  end

  // Next state of the execute sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (mem_start) begin
          state_d = IS_POW2 ? ST_MEM : ST_DIV1;
        end
      end
      ST_DIV1: state_d = ST_DIV2;
      ST_DIV2: state_d = ST_MEM;
      ST_MEM: begin
        if (is_ld_q) begin
          state_d = ST_LOAD;
        end else if (can_emit) begin
          state_d = ST_RUN;
        end
      end
      ST_LOAD: begin
        if (can_emit) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // The clear sweep owns the memory port right after reset.
  assign ram_addr  = clr_busy_q ? clr_cnt_q : addr_q;
  assign ram_wdata = clr_busy_q ? 16'd0 : rf_q[mrx_q];

  tce_ram #(
    .WIDTH (16),
    .DEPTH (MEM_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (ram_we || clr_busy_q),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Architectural state, clear sweep and output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      flag_q      <= CMP_EQ;
      pc_q        <= '0;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        rf_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      flag_q  <= flag_d;
      pc_q    <= pc_d;
      if (rf_we) begin
        rf_q[rf_wa] <= rf_wd;
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(MEM_WORDS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Memory operation operands and result payload.
  always_ff @(posedge clk_i) begin
    if (mem_start) begin
      mrx_q   <= q_head_i.rx;
      is_ld_q <= (q_head_i.kind == K_LOAD);
      ryv_q   <= ryv;
      addr_q  <= ryv[AW-1:0];
    end
    if (state_q == ST_DIV1) begin
      quot_q <= quot_d;
    end
    if (state_q == ST_DIV2) begin
      addr_q <= rem[AW-1:0];
    end
    if (emit) begin
      res_q    <= res_d;
      r0_q     <= r0_d;
      pc_out_q <= pc_d;
      cmp_q    <= flag_d;
      br_q     <= br_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign reg0_value_o   = r0_q;
  assign next_pc_o      = pc_out_q;
  assign compare_out_o  = cmp_q;
  assign was_branch_o   = br_q;

  `TCE_ASSERT_SAME(a_no_pop_in_mem_op, (state_q != ST_RUN), !pop_o, "pop during memory op")
  `TCE_ASSERT_SAME(a_clear_quiet, clr_busy_q, (state_q == ST_RUN) && !out_valid_q, "busy in clear")
  `TCE_ASSERT_NEXT(a_load_follows, (state_q == ST_MEM) && is_ld_q, (state_q == ST_LOAD), "load lost")

endmodule

/* hdl/tiny_cpu_instruction_executor.sv */
// Top level of the tiny CPU instruction executor.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   instr_word_i
//   out      output     out_valid_o / out_ready_i result_value_o, reg0_value_o,
//                                                 next_pc_o, compare_out_o, was_branch_o
//
// ALU and branch instructions retire one per cycle while the output is not stalled; each
// result passes through the queue and is then held in the output register.
// A load steps the execute sequencer through ST_MEM and ST_LOAD and a store through ST_MEM,
// after ST_DIV1 and ST_DIV2 when MEM_WORDS is not a power of two (address reduction by a two-step multiply).
// After reset the data memory is cleared one word a cycle, all MEM_WORDS words, and no
// request is taken until the sweep ends.
// A two-entry queue lets requests enter while the execute side waits on the output.
`timescale 1ns / 1ps
module tiny_cpu_instruction_executor #(
  parameter int unsigned MEM_WORDS = tce_pkg::TCE_MEM_WORDS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] instr_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_value_o,
  output logic [15:0] reg0_value_o,
  output logic [15:0] next_pc_o,
  output logic [1:0]  compare_out_o,
  output logic        was_branch_o
);
  import tce_pkg::*;

  logic push, full, pop, q_valid, back_ready;
  dec_t push_data, q_head;

  tce_front u_front (
    .enable_i     (back_ready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .instr_word_i (instr_word_i),
    .full_i       (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  tce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  tce_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_head_i       (q_head),
    .pop_o          (pop),
    .ready_o        (back_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .reg0_value_o   (reg0_value_o),
    .next_pc_o      (next_pc_o),
    .compare_out_o  (compare_out_o),
    .was_branch_o   (was_branch_o)
  );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the tiny CPU instruction executor.
`timescale 1ns / 1ps
module testbench;
  import tce_pkg::*;

  localparam int unsigned MEM_DEPTH = TCE_MEM_WORDS;
  // ALU opcodes in bits 2:0; format 00 gives INC and SHL, format 01 gives DEC and SHR.
  localparam logic [2:0] OPC_INC = 3'd0;
  localparam logic [2:0] OPC_DEC = 3'd1;
  localparam logic [2:0] OPC_SHL = 3'd4;
  localparam logic [2:0] OPC_SHR = 3'd5;
  // Bit 2 of a memory instruction selects the direction.
  localparam logic MEM_DIR_LOAD  = 1'b0;
  localparam logic MEM_DIR_STORE = 1'b1;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned TOP_STEPS = 16;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic [15:0] result;
    logic [15:0] reg0;
    logic [15:0] pc;
    logic [1:0]  flag;
    logic        branch;
  } step_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] instr_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] result_value_o;
  logic [15:0] reg0_value_o;
  logic [15:0] next_pc_o;
  logic [1:0]  compare_out_o;
  logic        was_branch_o;

  // Architectural state of the predictor.
  logic [15:0] cpu_regs [8];
  logic [15:0] cpu_mem [MEM_DEPTH];
  logic [1:0]  cpu_flag;
  logic [15:0] cpu_pc;

  step_result_t pending_q[$];
  step_result_t head;
  int unsigned  error_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  burst_left = 0;
  bit           pacing_on = 1'b1;
  bit           hold_req = 1'b0;

  tiny_cpu_instruction_executor #(
    .MEM_WORDS(MEM_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .instr_word_i  (instr_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_value_o(result_value_o),
    .reg0_value_o  (reg0_value_o),
    .next_pc_o     (next_pc_o),
    .compare_out_o (compare_out_o),
    .was_branch_o  (was_branch_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one instruction to the predictor state and return the retired values.
  function automatic step_result_t execute_instr(input logic [15:0] w);
    step_result_t r;
    logic [2:0]   rx;
    logic [2:0]   ry;
    logic [15:0]  v;
    int unsigned  addr;
    rx = w[15:13];
    ry = w[12:10];
    r.branch = 1'b0;
    if (w[1:0] == FMT_BRANCH) begin
      if (cpu_flag == w[3:2]) begin
        cpu_pc = {4'h0, w[15:4]};
      end else begin
        cpu_pc = cpu_pc + 16'd1;
      end
      r.branch = 1'b1;
      r.result = cpu_regs[0];
    end else if (w[1:0] == FMT_MEMORY) begin
      addr = cpu_regs[ry] % MEM_DEPTH;
      if (w[2] == MEM_DIR_STORE) begin
        cpu_mem[addr] = cpu_regs[rx];
      end else begin
        cpu_regs[rx] = cpu_mem[addr];
      end
      cpu_pc = cpu_pc + 16'd1;
      r.result = cpu_regs[rx];
    end else begin
      v = cpu_regs[rx];
      case (w[2:0])
        OPC_INC: v = v + 16'd1;
        OPC_DEC: v = v - 16'd1;
        OPC_SHL: v = v << 1;
        OPC_SHR: v = v >> 1;
        default: v = v;
      endcase
      cpu_regs[rx] = v;
      if (v == cpu_regs[ry]) begin
        cpu_flag = CMP_EQ;
      end else if (v > cpu_regs[ry]) begin
        cpu_flag = CMP_GT;
      end else begin
        cpu_flag = CMP_LT;
      end
      cpu_pc = cpu_pc + 16'd1;
      r.result = v;
    end
    r.reg0 = cpu_regs[0];
    r.pc = cpu_pc;
    r.flag = cpu_flag;
    return r;
  endfunction

  function automatic logic [15:0] alu_word(input logic [2:0] op, input logic [2:0] rx,
                                           input logic [2:0] ry);
    return {rx, ry, 7'h00, op};
  endfunction

  function automatic logic [15:0] mem_word(input logic dir, input logic [2:0] rx,
                                           input logic [2:0] ry);
    return {rx, ry, 7'h00, dir, FMT_MEMORY};
  endfunction

  function automatic logic [15:0] branch_word(input logic [1:0] cond,
                                              input logic [11:0] target);
    return {target, cond, FMT_BRANCH};
  endfunction

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace();
    int unsigned gap;
    if (pacing_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
  endtask

  // Offer one request and record its expected result once it is taken.
  task automatic issue_instr(input logic [15:0] w);
    pace();
    in_valid_i <= 1'b1;
    instr_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q = {pending_q, execute_instr(w)};
  endtask

  // Stop sending and wait until every outstanding result has been seen.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_alu_ops();
    issue_instr(alu_word(OPC_INC, 3'd0, 3'd1));
    // Decrement from zero wraps to all ones, and increment wraps back.
    issue_instr(alu_word(OPC_DEC, 3'd1, 3'd0));
    issue_instr(alu_word(OPC_INC, 3'd1, 3'd2));
    issue_instr(alu_word(OPC_SHL, 3'd0, 3'd7));
    issue_instr(alu_word(OPC_SHR, 3'd1, 3'd0));
    // Shifts drop the bit that leaves the word.
    issue_instr(alu_word(OPC_DEC, 3'd2, 3'd3));
    issue_instr(alu_word(OPC_SHL, 3'd2, 3'd3));
    issue_instr(alu_word(OPC_SHR, 3'd2, 3'd3));
  endtask

  task automatic test_memory_access();
    issue_instr(mem_word(MEM_DIR_STORE, 3'd2, 3'd0));
    issue_instr(mem_word(MEM_DIR_LOAD, 3'd3, 3'd0));
    // Register 2 holds 0x7FFF, so the address is truncated to the memory size.
    issue_instr(mem_word(MEM_DIR_STORE, 3'd0, 3'd2));
    issue_instr(mem_word(MEM_DIR_LOAD, 3'd4, 3'd2));
    issue_instr(mem_word(MEM_DIR_STORE, 3'd2, 3'd2));
    issue_instr(mem_word(MEM_DIR_LOAD, 3'd2, 3'd2));
  endtask

  task automatic test_branches();
    issue_instr(branch_word(cpu_flag, 12'hFFF));
    // Condition three never matches the flag.
    issue_instr(branch_word(2'd3, 12'h000));
    issue_instr(branch_word(cpu_flag + 2'd1, 12'h5A5));
    issue_instr(branch_word(cpu_flag, 12'h000));
  endtask

  // Results are held back long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    drain();
    hold_req = 1'b1;
    while (hold_req) @(posedge clk_i);
    pacing_on = 1'b0;
    for (int i = 0; i < 16; i++) begin
      issue_instr(i[0] ? 16'($urandom) : alu_word(3'($urandom_range(0, 1)), 3'($urandom),
                                                  3'($urandom)));
    end
    pacing_on = 1'b1;
    drain();
  endtask

  task automatic test_random_mix();
    int unsigned   sent;
    int unsigned   pick;
    logic [2:0]    ry;
    logic [15:0]   noise;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      noise = 16'($urandom);
      if (pick < 6) begin
        issue_instr(noise);
        sent++;
      end else if (pick < 8) begin
        // Store then load through the same address register.
        ry = 3'($urandom);
        issue_instr({3'($urandom), ry, noise[9:3], MEM_DIR_STORE, FMT_MEMORY});
        issue_instr({3'($urandom), ry, noise[9:3], MEM_DIR_LOAD, FMT_MEMORY});
        sent += 2;
      end else if (pick == 8) begin
        issue_instr(branch_word(cpu_flag, noise[15:4]));
        sent++;
      end else begin
        issue_instr({noise[15:3], 1'($urandom), 2'($urandom_range(0, 1))});
        sent++;
      end
    end
  endtask

  // Jump to the top of the branch range, then step past it so the counter leaves the 12-bit target range.
  task automatic test_branch_top();
    drain();
    issue_instr(branch_word(cpu_flag, 12'hFFF));
    pacing_on = 1'b0;
    for (int unsigned i = 0; i < TOP_STEPS; i++) begin
      issue_instr({13'($urandom), 1'($urandom), 2'($urandom_range(0, 1))});
    end
    pacing_on = 1'b1;
  endtask

  // Stimulus sequence.
  initial begin
    for (int i = 0; i < 8; i++) cpu_regs[i] = '0;
    for (int i = 0; i < MEM_DEPTH; i++) cpu_mem[i] = '0;
    cpu_flag = CMP_EQ;
    cpu_pc = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_alu_ops();
    test_memory_access();
    test_branches();
    test_output_backpressure();
    test_random_mix();
    test_branch_top();
    drain();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: changing ready patterns, plus one long hold-off on request.
  initial begin : receiver
    int unsigned mode;
    int unsigned phase_left;
    int unsigned hold_left;
    mode = 0;
    phase_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 3);
          phase_left = $urandom_range(8, 60);
        end
        phase_left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 9) < 7);
          2: out_ready_i <= ($urandom_range(0, 9) < 3);
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s expected %h, got %h", $time, what, exp_v, act_v);
    end else if (error_count == MAX_REPORTS + 1) begin
      $display("%0t: further mismatches are counted without detail", $time);
    end
  endtask

  // Compare each accepted result with the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result with no request pending, result_value", 16'hxxxx,
                        result_value_o);
      end else begin
        head = pending_q.pop_front();
        if (result_value_o !== head.result)
          report_mismatch("result_value", head.result, result_value_o);
        if (reg0_value_o !== head.reg0)
          report_mismatch("reg0_value", head.reg0, reg0_value_o);
        if (next_pc_o !== head.pc)
          report_mismatch("next_pc", head.pc, next_pc_o);
        if (compare_out_o !== head.flag)
          report_mismatch("compare_out", 16'(head.flag), 16'(compare_out_o));
        if (was_branch_o !== head.branch)
          report_mismatch("was_branch", 16'(head.branch), 16'(was_branch_o));
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
